### sv/ucf_pkg.sv
// Shared types, codes and command patterns of the serial command framer.
`timescale 1ns / 1ps

package ucf_pkg;

	localparam logic [1:0] KIND_BYTE   = 2'd0;
	localparam logic [1:0] KIND_ANSWER = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;

	localparam logic [1:0] RK_REPLY   = 2'd0;
	localparam logic [1:0] RK_REQUEST = 2'd1;
	localparam logic [1:0] RK_MESSAGE = 2'd2;

	localparam logic [1:0] RC_OK    = 2'd0;
	localparam logic [1:0] RC_WAIT  = 2'd1;
	localparam logic [1:0] RC_ERROR = 2'd2;

	localparam logic [2:0] REQ_SCAN_START = 3'd0;
	localparam logic [2:0] REQ_SCAN_STOP  = 3'd1;
	localparam logic [2:0] REQ_FOUND      = 3'd2;
	localparam logic [2:0] REQ_CONNECT    = 3'd3;
	localparam logic [2:0] REQ_SWITCH     = 3'd4;
	localparam logic [2:0] REQ_DROP       = 3'd5;
	localparam logic [2:0] REQ_SYS_RESET  = 3'd6;

	localparam logic [7:0] CH_DOT  = 8'h2E;
	localparam logic [7:0] CH_STAR = 8'h2A;

	localparam logic [23:0] PFX_AT_PLUS  = "AT+";
	localparam logic [23:0] PFX_AT_QUERY = "AT?";
	localparam logic [39:0] CMD_SCAN_START = "SCAN+";
	localparam logic [39:0] CMD_SCAN_STOP  = "SCAN-";
	localparam logic [47:0] CMD_FOUND      = "FOUND=";
	localparam logic [39:0] CMD_CONN       = "CONN=";
	localparam logic [55:0] CMD_SWITCH     = "SWITCH=";
	localparam logic [39:0] CMD_DROP       = "DROP=";
	localparam logic [31:0] CMD_AUTO       = "AUTO";
	localparam logic [39:0] CMD_RESET      = "RESET";

	localparam logic [3:0] NIBBLE_MASK = 4'hF;

	// Number of leading line bytes that command matching looks at.
	localparam int PFX_BYTES = 11;
	localparam int MSG_MAX   = 15;

	typedef enum logic [1:0] {
		PEND_NONE,
		PEND_CONN,
		PEND_SWITCH,
		PEND_DROP
	} pend_t;

	typedef enum logic [1:0] {
		CL_NONE,
		CL_PARSE,
		CL_MSG,
		CL_REPLY
	} class_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PARSE,
		ST_EMIT,
		ST_MSG_RD,
		ST_MSG_OUT
	} state_t;

	typedef struct packed {
		logic [1:0] result_kind;
		logic [1:0] reply_code;
		logic [2:0] request_code;
		logic [3:0] device_index;
		logic [7:0] message_byte;
		logic [3:0] message_length;
		logic       last;
	} result_t;

	typedef struct packed {
		logic in_ready;
		logic capture;
		logic parse;
		logic emit_pair;
		logic msg_rd;
		logic msg_emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic   in_valid;
		class_t in_class;
		logic   two_left;
		logic   out_free;
		logic   msg_last;
	} ctrl_status_t;

	function automatic result_t mk_reply(input logic [1:0] code, input logic last);
		result_t r;
		r = '0;
		r.result_kind = RK_REPLY;
		r.reply_code  = code;
		r.last        = last;
		return r;
	endfunction

	function automatic result_t mk_request(input logic [2:0] code, input logic [3:0] idx,
			input logic last);
		result_t r;
		r = '0;
		r.result_kind  = RK_REQUEST;
		r.request_code = code;
		r.device_index = idx;
		r.last         = last;
		return r;
	endfunction

endpackage

### sv/ucf_if.sv
// Valid/ready channel interfaces for input items and result items.
`timescale 1ns / 1ps

interface ucf_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] rx_byte;
	logic       answer_ok;

	modport source(output valid, kind, rx_byte, answer_ok, input ready);
	modport sink(input valid, kind, rx_byte, answer_ok, output ready);
endinterface

interface ucf_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] result_kind;
	logic [1:0] reply_code;
	logic [2:0] request_code;
	logic [3:0] device_index;
	logic [7:0] message_byte;
	logic [3:0] message_length;
	logic       last;

	modport source(output valid, result_kind, reply_code, request_code, device_index,
		message_byte, message_length, last, input ready);
	modport sink(input valid, result_kind, reply_code, request_code, device_index,
		message_byte, message_length, last, output ready);
endinterface

### sv/ucf_ctrl.sv
// Sequencing state machine of the serial command framer.
`timescale 1ns / 1ps

module ucf_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ucf_pkg::ctrl_status_t status,
	output ucf_pkg::ctrl_cmd_t    cmd
);

	ucf_pkg::state_t state_q;
	ucf_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ucf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ucf_pkg::ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (status.in_valid) begin
					cmd.capture = 1'b1;
					case (status.in_class)
						ucf_pkg::CL_PARSE: state_d = ucf_pkg::ST_PARSE;
						ucf_pkg::CL_MSG:   state_d = ucf_pkg::ST_MSG_RD;
						ucf_pkg::CL_REPLY: state_d = ucf_pkg::ST_EMIT;
						default:           state_d = ucf_pkg::ST_IDLE;
					endcase
				end
			end
			ucf_pkg::ST_PARSE: begin
				cmd.parse = 1'b1;
				state_d   = ucf_pkg::ST_EMIT;
			end
			ucf_pkg::ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit_pair = 1'b1;
					if (!status.two_left) begin
						state_d = ucf_pkg::ST_IDLE;
					end
				end
			end
			ucf_pkg::ST_MSG_RD: begin
				cmd.msg_rd = 1'b1;
				state_d    = ucf_pkg::ST_MSG_OUT;
			end
			ucf_pkg::ST_MSG_OUT: begin
				if (status.out_free) begin
					cmd.msg_emit = 1'b1;
					if (status.msg_last) begin
						state_d = ucf_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ucf_pkg::ST_IDLE;
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_parse_then_emit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ucf_pkg::ST_PARSE |=> state_q == ucf_pkg::ST_EMIT)
		else $error("Parse step was not followed by result emission.");

	a_msg_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ucf_pkg::ST_MSG_OUT && status.out_free && status.msg_last)
		|=> state_q == ucf_pkg::ST_IDLE)
		else $error("Message did not end after its final byte.");

	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture, cmd.parse, cmd.emit_pair, cmd.msg_rd, cmd.msg_emit}))
		else $error("More than one datapath action in one cycle.");
`endif

endmodule

### sv/ucf_dpath.sv
// Line store, command matcher, link state and result register of the framer.
`timescale 1ns / 1ps

module ucf_dpath #(
	parameter int LINE_DEPTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ucf_pkg::ctrl_cmd_t    cmd,
	output ucf_pkg::ctrl_status_t status,
	ucf_item_if.sink              items,
	ucf_result_if.source          results
);

	localparam int AW = $clog2(LINE_DEPTH);
	localparam int LW = (AW > 4) ? AW : 4;

	logic [7:0]             mem_q [LINE_DEPTH];
	logic [LINE_DEPTH-1:0]  vld_q;
	logic [7:0]             pfx_q [ucf_pkg::PFX_BYTES];
	logic [AW-1:0]          wi_q;
	logic                   cmd_mode_q;
	ucf_pkg::pend_t         pend_q;
	ucf_pkg::result_t       r0_q;
	ucf_pkg::result_t       r1_q;
	logic                   two_q;
	logic [AW-1:0]          msg_len_q;
	logic [3:0]             msg_cnt_q;
	logic [7:0]             rd_q;
	ucf_pkg::result_t       out_q;
	logic                   out_valid_q;

	logic                   is_dot;
	logic                   is_star;
	logic                   store_en;
	logic                   out_free;
	logic [AW-1:0]          wi_next;
	ucf_pkg::class_t        in_class;
	ucf_pkg::result_t       p_r0;
	ucf_pkg::result_t       p_r1;
	logic                   p_two;
	logic                   p_mode;
	ucf_pkg::pend_t         p_pend;
	ucf_pkg::result_t       a_res;
	logic                   a_mode;
	logic                   at_plus;
	logic                   at_query;
	logic [LW-1:0]          len_ext;
	logic [LW-1:0]          msg_lim;
	logic                   msg_empty;
	logic                   msg_last;
	logic                   rd_en;
	logic [3:0]             cnt_next;
	logic [AW-1:0]          rd_addr;
	ucf_pkg::result_t       msg_res;

	assign is_dot   = (items.rx_byte == ucf_pkg::CH_DOT);
	assign is_star  = (items.rx_byte == ucf_pkg::CH_STAR);
	assign store_en = cmd.capture && (items.kind == ucf_pkg::KIND_BYTE)
		&& (pend_q == ucf_pkg::PEND_NONE);
	assign out_free = !out_valid_q || results.ready;
	assign wi_next  = (wi_q == AW'(LINE_DEPTH - 1)) ? '0 : wi_q + AW'(1);

	always_comb begin
		in_class = ucf_pkg::CL_NONE;
		if (items.kind == ucf_pkg::KIND_ANSWER) begin
			if (pend_q != ucf_pkg::PEND_NONE) begin
				in_class = ucf_pkg::CL_REPLY;
			end
		end else if (items.kind == ucf_pkg::KIND_BYTE && pend_q == ucf_pkg::PEND_NONE) begin
			if (cmd_mode_q) begin
				if (is_dot) begin
					in_class = ucf_pkg::CL_PARSE;
				end
			end else if (is_dot) begin
				in_class = ucf_pkg::CL_MSG;
			end else if (is_star) begin
				in_class = ucf_pkg::CL_REPLY;
			end
		end
	end

	// Command matching works on the registered copy of the leading line bytes.
	assign at_plus  = ({pfx_q[0], pfx_q[1], pfx_q[2]} == ucf_pkg::PFX_AT_PLUS);
	assign at_query = ({pfx_q[0], pfx_q[1], pfx_q[2]} == ucf_pkg::PFX_AT_QUERY);

	always_comb begin
		p_r0   = ucf_pkg::mk_reply(ucf_pkg::RC_ERROR, 1'b1);
		p_r1   = ucf_pkg::mk_reply(ucf_pkg::RC_OK, 1'b1);
		p_two  = 1'b0;
		p_mode = cmd_mode_q;
		p_pend = pend_q;
		if (at_plus) begin
			if ({pfx_q[3], pfx_q[4], pfx_q[5], pfx_q[6], pfx_q[7]}
					== ucf_pkg::CMD_SCAN_START) begin
				p_r0  = ucf_pkg::mk_request(ucf_pkg::REQ_SCAN_START, 4'd0, 1'b0);
				p_r1  = ucf_pkg::mk_reply(ucf_pkg::RC_OK, 1'b1);
				p_two = 1'b1;
			end else if ({pfx_q[3], pfx_q[4], pfx_q[5], pfx_q[6], pfx_q[7]}
					== ucf_pkg::CMD_SCAN_STOP) begin
				p_r0 = ucf_pkg::mk_request(ucf_pkg::REQ_SCAN_STOP, 4'd0, 1'b1);
			end else if ({pfx_q[3], pfx_q[4], pfx_q[5], pfx_q[6], pfx_q[7], pfx_q[8]}
					== ucf_pkg::CMD_FOUND) begin
				p_r0 = ucf_pkg::mk_request(ucf_pkg::REQ_FOUND,
					pfx_q[9][3:0] & ucf_pkg::NIBBLE_MASK, 1'b1);
			end else if ({pfx_q[3], pfx_q[4], pfx_q[5], pfx_q[6], pfx_q[7]}
					== ucf_pkg::CMD_CONN) begin
				p_r0   = ucf_pkg::mk_request(ucf_pkg::REQ_CONNECT,
					pfx_q[8][3:0] & ucf_pkg::NIBBLE_MASK, 1'b1);
				p_pend = ucf_pkg::PEND_CONN;
			end else if ({pfx_q[3], pfx_q[4], pfx_q[5], pfx_q[6], pfx_q[7], pfx_q[8],
					pfx_q[9]} == ucf_pkg::CMD_SWITCH) begin
				p_r0   = ucf_pkg::mk_request(ucf_pkg::REQ_SWITCH,
					pfx_q[10][3:0] & ucf_pkg::NIBBLE_MASK, 1'b1);
				p_pend = ucf_pkg::PEND_SWITCH;
			end else if ({pfx_q[3], pfx_q[4], pfx_q[5], pfx_q[6], pfx_q[7]}
					== ucf_pkg::CMD_DROP) begin
				p_r0   = ucf_pkg::mk_request(ucf_pkg::REQ_DROP,
					pfx_q[8][3:0] & ucf_pkg::NIBBLE_MASK, 1'b1);
				p_pend = ucf_pkg::PEND_DROP;
			end else if ({pfx_q[3], pfx_q[4], pfx_q[5], pfx_q[6]} == ucf_pkg::CMD_AUTO) begin
				p_r0   = ucf_pkg::mk_reply(ucf_pkg::RC_OK, 1'b1);
				p_mode = 1'b0;
			end else if ({pfx_q[3], pfx_q[4], pfx_q[5], pfx_q[6], pfx_q[7]}
					== ucf_pkg::CMD_RESET) begin
				p_r0  = ucf_pkg::mk_reply(ucf_pkg::RC_OK, 1'b0);
				p_r1  = ucf_pkg::mk_request(ucf_pkg::REQ_SYS_RESET, 4'd0, 1'b1);
				p_two = 1'b1;
			end
		end else if (at_query) begin
			p_r0 = ucf_pkg::mk_reply(ucf_pkg::RC_OK, 1'b1);
		end
	end

	always_comb begin
		a_mode = cmd_mode_q;
		a_res  = ucf_pkg::mk_reply(ucf_pkg::RC_ERROR, 1'b1);
		case (pend_q)
			ucf_pkg::PEND_CONN: begin
				if (items.answer_ok) begin
					a_mode = 1'b0;
					a_res  = ucf_pkg::mk_reply(ucf_pkg::RC_WAIT, 1'b1);
				end
			end
			ucf_pkg::PEND_SWITCH: begin
				if (items.answer_ok) begin
					a_mode = 1'b0;
					a_res  = ucf_pkg::mk_reply(ucf_pkg::RC_OK, 1'b1);
				end
			end
			ucf_pkg::PEND_DROP: begin
				if (items.answer_ok) begin
					a_res = ucf_pkg::mk_reply(ucf_pkg::RC_WAIT, 1'b1);
				end
			end
			default: begin
				a_mode = cmd_mode_q;
			end
		endcase
	end

	assign len_ext   = LW'(msg_len_q);
	assign msg_lim   = (len_ext > LW'(ucf_pkg::MSG_MAX)) ? LW'(ucf_pkg::MSG_MAX) : len_ext;
	assign msg_empty = (msg_len_q == '0);
	assign msg_last  = msg_empty || ((LW'(msg_cnt_q) + LW'(1)) == msg_lim);
	assign cnt_next  = msg_cnt_q + 4'd1;
	assign rd_en     = cmd.msg_rd || (cmd.msg_emit && !msg_last);
	assign rd_addr   = cmd.msg_emit ? AW'(cnt_next) : AW'(msg_cnt_q);

	always_comb begin
		msg_res                = '0;
		msg_res.result_kind    = ucf_pkg::RK_MESSAGE;
		msg_res.message_byte   = msg_empty ? 8'h00 : rd_q;
		msg_res.message_length = len_ext[3:0];
		msg_res.last           = msg_last;
	end

	// Line store memory; the valid bits stand for the cleared reset contents.
	always_ff @(posedge clk) begin
		if (store_en) begin
			mem_q[wi_q] <= items.rx_byte;
		end
		if (rd_en) begin
			rd_q <= vld_q[rd_addr] ? mem_q[rd_addr] : 8'h00;
		end
	end

	for (genvar k = 0; k < ucf_pkg::PFX_BYTES; k++) begin : g_pfx
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pfx_q[k] <= '0;
			end else if (store_en && (k < LINE_DEPTH) && (wi_q == AW'(k))) begin
				pfx_q[k] <= items.rx_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			wi_q        <= '0;
			cmd_mode_q  <= 1'b1;
			pend_q      <= ucf_pkg::PEND_NONE;
			two_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (store_en) begin
				vld_q[wi_q] <= 1'b1;
				if (is_dot || (!cmd_mode_q && is_star)) begin
					wi_q <= '0;
				end else begin
					wi_q <= wi_next;
				end
				if (!cmd_mode_q && is_star) begin
					cmd_mode_q <= 1'b1;
				end
			end
			if (cmd.capture && items.kind == ucf_pkg::KIND_CLEAR) begin
				wi_q <= '0;
			end
			if (cmd.capture && items.kind == ucf_pkg::KIND_ANSWER) begin
				cmd_mode_q <= a_mode;
				pend_q     <= ucf_pkg::PEND_NONE;
			end
			if (cmd.capture) begin
				two_q <= 1'b0;
			end
			if (cmd.parse) begin
				cmd_mode_q <= p_mode;
				pend_q     <= p_pend;
				two_q      <= p_two;
			end
			if (cmd.emit_pair) begin
				two_q <= 1'b0;
			end
			if (cmd.emit_pair || cmd.msg_emit) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			r0_q <= (items.kind == ucf_pkg::KIND_ANSWER) ? a_res
				: ucf_pkg::mk_reply(ucf_pkg::RC_OK, 1'b1);
			if (in_class == ucf_pkg::CL_MSG) begin
				msg_len_q <= wi_q;
				msg_cnt_q <= 4'd0;
			end
		end
		if (cmd.parse) begin
			r0_q <= p_r0;
			r1_q <= p_r1;
		end
		if (cmd.emit_pair) begin
			out_q <= r0_q;
			r0_q  <= r1_q;
		end
		if (cmd.msg_emit) begin
			out_q <= msg_res;
			if (!msg_last) begin
				msg_cnt_q <= cnt_next;
			end
		end
	end

	assign items.ready            = cmd.in_ready;
	assign results.valid          = out_valid_q;
	assign results.result_kind    = out_q.result_kind;
	assign results.reply_code     = out_q.reply_code;
	assign results.request_code   = out_q.request_code;
	assign results.device_index   = out_q.device_index;
	assign results.message_byte   = out_q.message_byte;
	assign results.message_length = out_q.message_length;
	assign results.last           = out_q.last;

	assign status.in_valid = items.valid;
	assign status.in_class = in_class;
	assign status.two_left = two_q;
	assign status.out_free = out_free;
	assign status.msg_last = msg_last;

`ifndef ASSERT_OFF
	a_wi_range: assert property (@(posedge clk) disable iff (!arst_n)
		wi_q <= AW'(LINE_DEPTH - 1))
		else $error("Write index left the line store.");

	a_pend_cmd_mode: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != ucf_pkg::PEND_NONE |-> cmd_mode_q)
		else $error("Link request pending outside command mode.");

	a_msg_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.msg_emit |-> (LW'(msg_cnt_q) < msg_lim) || msg_empty)
		else $error("Message byte count ran past the message length.");
`endif

endmodule

### sv/uart_at_command_framer.sv
// Top level of the serial command framer: controller and datapath.
//
//   Channel   Dir   Payload                                         Accept
//   items     in    kind, rx_byte, answer_ok                       valid & ready
//   results   out   result_kind, reply_code, request_code,
//                   device_index, message_byte, message_length,
//                   last                                           valid & ready
//
// A plain byte, clear or answer with no reply is taken at capture. An answer reply or a
// return to command mode is captured and emitted; a command line end is parsed too and
// gives one or two results. A data message gives one byte per cycle while the output is
// free, from the line store read port, at most 15 bytes; an empty message gives a single
// result. A result stall holds the sequencer; a new request is taken once the last result
// of the current one is in the output register. Reset clears the store through valid bits.
`timescale 1ns / 1ps

module uart_at_command_framer #(
	parameter int LINE_DEPTH = 16
) (
	input logic          clk,
	input logic          arst_n,
	ucf_item_if.sink     items,
	ucf_result_if.source results
);

	ucf_pkg::ctrl_cmd_t    cmd;
	ucf_pkg::ctrl_status_t status;

	ucf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd)
	);

	ucf_dpath #(
		.LINE_DEPTH (LINE_DEPTH)
	) u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.status  (status),
		.items   (items),
		.results (results)
	);

endmodule
